// File: rtl/core/lbachs_pkg.sv
// Shared constants for the logical block address to cylinder/head/sector converter.
`timescale 1ns / 1ps
`default_nettype none
package lbachs_pkg;

	localparam int LBA_WIDTH_DEF = 32;
	localparam int ADDR_W        = 32;
	localparam int SPT_W         = 6;
	localparam int HEADS_W       = 9;
	localparam int CFG_W         = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int CYL_W         = 16;
	localparam int HEAD_W        = 8;
	localparam int SECTOR_W      = 6;
	localparam int OUT_DATA_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SPT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADS = 2'd1;

	localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd18;
	localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd2;
	localparam logic [HEADS_W-1:0] MAX_HEADS   = 9'd256;
	localparam logic [CYL_W-1:0]   CYL_MAX     = 16'hFFFF;

endpackage
`default_nettype wire

// File: rtl/core/lba_to_chs_convert.sv
// Top level: logical block address to cylinder/head/sector conversion.
//
//  channel | dir | handshake        | contents
//  s_*     | in  | s_tvalid/tready  | block address
//  m_*     | out | m_tvalid/tready  | cylinder, head, sector, overflow
//  cfg_*   | in  | cfg_we           | geometry registers, no read-back
//
// One address is accepted every cycle while the output is not stalled; each
// result passes through two rows of one-bit division cells (address / sectors
// per track, then track / head count). The last cell is the output register.
// Both rows advance when the output is empty or taken; a stalled output
// holds every cell. Reset clears valid bits and restores the geometry 18/2.
`timescale 1ns / 1ps
`default_nettype none
module lba_to_chs_convert #(
	parameter int LBA_WIDTH = lbachs_pkg::LBA_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// s_tdata: [31:0] block_address
	input  wire logic [lbachs_pkg::ADDR_W-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata: [15:0] cylinder, [23:16] head, [29:24] sector, [30] overflow, [31] zero
	output logic [lbachs_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [lbachs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lbachs_pkg::CFG_W-1:0]     cfg_data
);

	import lbachs_pkg::*;

	logic [SPT_W-1:0]     spt_q;
	logic [HEADS_W-1:0]   heads_q;
	logic [SPT_W-1:0]     spt_eff;
	logic [HEADS_W-1:0]   heads_eff;
	logic                 advance;
	logic [LBA_WIDTH-1:0] lba;

	logic                 valid1;
	logic [LBA_WIDTH-1:0] track1;
	logic [SPT_W-1:0]     srem1;
	logic [SECTOR_W-1:0]  sector1;

	logic                 valid2;
	logic [LBA_WIDTH-1:0] cyl_full;
	logic [HEADS_W-1:0]   hrem2;
	logic [SECTOR_W-1:0]  sector2;
	logic                 ovf;
	logic [CYL_W-1:0]     cyl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q   <= SPT_RESET;
			heads_q <= HEADS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPT:   spt_q   <= cfg_data[SPT_W-1:0];
				REG_HEADS: heads_q <= cfg_data[HEADS_W-1:0];
				default:   ;
			endcase
		end
	end

	// zero divisors act as one, head count clamps at 256
	always_comb begin
		spt_eff = (spt_q == '0) ? SPT_W'(1) : spt_q;
		if (heads_q == '0) begin
			heads_eff = HEADS_W'(1);
		end else if (heads_q > MAX_HEADS) begin
			heads_eff = MAX_HEADS;
		end else begin
			heads_eff = heads_q;
		end
	end

	assign advance  = !valid2 || m_tready;
	assign s_tready = advance;
	assign lba      = LBA_WIDTH'(s_tdata);

	lbachs_div_chain #(
		.NUM_W  (LBA_WIDTH),
		.DEN_W  (SPT_W),
		.SIDE_W (1)
	) u_spt_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (s_tvalid),
		.in_num    (lba),
		.in_side   (1'b0),
		.den       (spt_eff),
		.out_valid (valid1),
		.out_quo   (track1),
		.out_rem   (srem1),
		.out_side  ()
	);

	assign sector1 = srem1 + SECTOR_W'(1);

	lbachs_div_chain #(
		.NUM_W  (LBA_WIDTH),
		.DEN_W  (HEADS_W),
		.SIDE_W (SECTOR_W)
	) u_head_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (valid1),
		.in_num    (track1),
		.in_side   (sector1),
		.den       (heads_eff),
		.out_valid (valid2),
		.out_quo   (cyl_full),
		.out_rem   (hrem2),
		.out_side  (sector2)
	);

	if (LBA_WIDTH > CYL_W) begin : g_sat
		assign ovf = |cyl_full[LBA_WIDTH-1:CYL_W];
	end else begin : g_nosat
		assign ovf = 1'b0;
	end

	// saturate the cylinder, head and sector stay true
	assign cyl      = ovf ? CYL_MAX : cyl_full[CYL_W-1:0];
	assign m_tvalid = valid2;
	assign m_tdata  = {1'b0, ovf, sector2, hrem2[HEAD_W-1:0], cyl};

endmodule
`default_nettype wire

// File: rtl/core/lbachs_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle while advance is high.
`timescale 1ns / 1ps
`default_nettype none
module lbachs_div_cell #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 6,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              valid_i,
	input  wire logic [NUM_W-1:0]  num_i,
	input  wire logic [DEN_W-1:0]  rem_i,
	input  wire logic [SIDE_W-1:0] side_i,
	input  wire logic [DEN_W-1:0]  den,
	output logic                   valid_o,
	output logic [NUM_W-1:0]       num_o,
	output logic [DEN_W-1:0]       rem_o,
	output logic [SIDE_W-1:0]      side_o
);

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;
	logic [DEN_W-1:0] rem_next;
	logic [NUM_W-1:0] num_next;
	logic             valid_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [SIDE_W-1:0] side_q;

	always_comb begin
		// bring down the next dividend bit, subtract when it fits
		trial    = {rem_i, num_i[NUM_W-1]};
		ge       = (trial >= {1'b0, den});
		diff     = trial - {1'b0, den};
		rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		num_next = {num_i[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			num_q  <= num_next;
			rem_q  <= rem_next;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign num_o   = num_q;
	assign rem_o   = rem_q;
	assign side_o  = side_q;

endmodule
`default_nettype wire

// File: rtl/core/lbachs_div_chain.sv
// Row of division cells: NUM_W cells yield quotient and remainder of num / den.
`timescale 1ns / 1ps
`default_nettype none
module lbachs_div_chain #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 6,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [SIDE_W-1:0] in_side,
	input  wire logic [DEN_W-1:0]  den,
	output logic                   out_valid,
	output logic [NUM_W-1:0]       out_quo,
	output logic [DEN_W-1:0]       out_rem,
	output logic [SIDE_W-1:0]      out_side
);

	logic              valid_c [NUM_W+1];
	logic [NUM_W-1:0]  num_c   [NUM_W+1];
	logic [DEN_W-1:0]  rem_c   [NUM_W+1];
	logic [SIDE_W-1:0] side_c  [NUM_W+1];

	assign valid_c[0] = in_valid;
	assign num_c[0]   = in_num;
	assign rem_c[0]   = '0;
	assign side_c[0]  = in_side;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		lbachs_div_cell #(
			.NUM_W  (NUM_W),
			.DEN_W  (DEN_W),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.valid_i (valid_c[i]),
			.num_i   (num_c[i]),
			.rem_i   (rem_c[i]),
			.side_i  (side_c[i]),
			.den     (den),
			.valid_o (valid_c[i+1]),
			.num_o   (num_c[i+1]),
			.rem_o   (rem_c[i+1]),
			.side_o  (side_c[i+1])
		);
	end

	assign out_valid = valid_c[NUM_W];
	assign out_quo   = num_c[NUM_W];
	assign out_rem   = rem_c[NUM_W];
	assign out_side  = side_c[NUM_W];

endmodule
`default_nettype wire
